// ===== rtl/core/bounded_value_list_macros.svh =====
// Assertion macros for the bounded value list block.
`ifndef BOUNDED_VALUE_LIST_MACROS_SVH
`define BOUNDED_VALUE_LIST_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, off during reset
`define BVL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bounded_value_list: implication check failed");
// next-cycle implication
`define BVL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bounded_value_list: next-cycle check failed");
`else
`define BVL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define BVL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/bvl_pkg.sv =====
// Shared types and constants for the bounded value list.
package bvl_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int VAL_W     = 32;
  localparam int FLD_W     = 6;   // width of the count fields in a result

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef struct packed {
    logic             status;
    logic [FLD_W-1:0] entry_count;
    logic [FLD_W-1:0] removed_count;
    logic             found;
  } result_t;

endpackage

// ===== rtl/core/bvl_mem.sv =====
// Value store: synchronous RAM, one write and one read port, registered read data.
module bvl_mem #(
  parameter int DEPTH = bvl_pkg::DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic signed [bvl_pkg::VAL_W-1:0]       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic signed [bvl_pkg::VAL_W-1:0]       rd_data
);

  logic signed [bvl_pkg::VAL_W-1:0] store_r [DEPTH];
  logic signed [bvl_pkg::VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/bvl_ctrl.sv =====
// Request sequencer: fill count, scan/compaction walk over the store, result register.
module bvl_ctrl #(
  parameter int DEPTH = bvl_pkg::DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // request side
  input  logic                                   req_valid,
  output logic                                   req_ready,
  input  bvl_pkg::req_t                          req_type,
  input  logic signed [bvl_pkg::VAL_W-1:0]       req_value,
  // store ports
  output logic                                   wr_en,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  output logic signed [bvl_pkg::VAL_W-1:0]       wr_data,
  output logic                                   rd_en,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  input  logic signed [bvl_pkg::VAL_W-1:0]       rd_data,
  // result side
  output logic                                   res_valid,
  input  logic                                   res_ready,
  output bvl_pkg::result_t                       res
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int FW = bvl_pkg::FLD_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

  state_t                           state_r, state_nxt;
  bvl_pkg::req_t                    req_r, req_nxt;
  logic signed [bvl_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [CW-1:0]                    fill_r, fill_nxt;
  logic [CW-1:0]                    idx_r, idx_nxt;
  logic [CW-1:0]                    keep_r, keep_nxt;
  logic [CW-1:0]                    rmv_r, rmv_nxt;
  logic                             found_r, found_nxt;
  logic                             status_r, status_nxt;
  logic                             pend_r;
  logic                             res_vld_r, res_vld_nxt;
  bvl_pkg::result_t                 res_r, res_nxt;

  logic          accept;
  logic          hit;
  logic          issue;
  logic [CW+FW-1:0] rmv_ext;
  logic [CW+FW-1:0] fill_ext;

  assign req_ready = (state_r == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign issue     = (state_r == ST_SCAN) && (idx_r < fill_r);
  assign hit       = (rd_data == val_r);

  assign rd_en   = issue;
  assign rd_addr = idx_r[AW-1:0];

  // counts are reported on FW bits, truncated when DEPTH is large
  assign rmv_ext  = {{FW{1'b0}}, rmv_r};
  assign fill_ext = {{FW{1'b0}}, fill_r};

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    val_nxt     = val_r;
    fill_nxt    = fill_r;
    idx_nxt     = idx_r;
    keep_nxt    = keep_r;
    rmv_nxt     = rmv_r;
    found_nxt   = found_r;
    status_nxt  = status_r;
    res_nxt     = res_r;
    res_vld_nxt = res_vld_r && !res_ready;
    wr_en       = 1'b0;
    wr_addr     = fill_r[AW-1:0];
    wr_data     = req_value;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt    = req_type;
          val_nxt    = req_value;
          idx_nxt    = '0;
          keep_nxt   = '0;
          rmv_nxt    = '0;
          found_nxt  = 1'b0;
          status_nxt = 1'b0;
          unique case (req_type)
            bvl_pkg::REQ_APPEND: begin
              state_nxt = ST_RESP;
              if (fill_r == FULL_CNT) begin
                status_nxt = 1'b1;
              end else begin
                wr_en    = 1'b1;
                fill_nxt = fill_r + 1'b1;
              end
            end
            bvl_pkg::REQ_CLEAR: begin
              state_nxt = ST_RESP;
              fill_nxt  = '0;
            end
            bvl_pkg::REQ_LOOKUP,
            bvl_pkg::REQ_REMOVE: begin
              state_nxt = ST_SCAN;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        // keep <= index read, so a write never lands on an entry still to be read
        if (pend_r) begin
          if (hit) begin
            found_nxt = 1'b1;
            rmv_nxt   = rmv_r + 1'b1;
          end else if (req_r == bvl_pkg::REQ_REMOVE) begin
            wr_en    = 1'b1;
            wr_addr  = keep_r[AW-1:0];
            wr_data  = rd_data;
            keep_nxt = keep_r + 1'b1;
          end
        end
        if (!issue && !pend_r) begin
          if (req_r == bvl_pkg::REQ_REMOVE) begin
            fill_nxt = keep_r;
          end
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!res_vld_r || res_ready) begin
          res_nxt.found         = found_r && (req_r == bvl_pkg::REQ_LOOKUP ||
                                              req_r == bvl_pkg::REQ_REMOVE);
          res_nxt.removed_count = (req_r == bvl_pkg::REQ_REMOVE) ? rmv_ext[FW-1:0] : '0;
          res_nxt.entry_count   = fill_ext[FW-1:0];
          res_nxt.status        = status_r;
          res_vld_nxt           = 1'b1;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      idx_r     <= '0;
      pend_r    <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      idx_r     <= idx_nxt;
      pend_r    <= issue;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    val_r    <= val_nxt;
    keep_r   <= keep_nxt;
    rmv_r    <= rmv_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    res_r    <= res_nxt;
  end

  assign res_valid = res_vld_r;
  assign res       = res_r;

endmodule

// ===== rtl/core/bounded_value_list.sv =====
// Top level of the bounded value list: ordered store of signed values with append/lookup/remove/clear.
//
//   chan | dir | tdata (from bit 0 up)                                | tuser
//   in_  | in  | [31:0] value                                         | [1:0] req_type
//   out_ | out | [0] found [6:1] removed [12:7] entries [13] status    | -
//
// Append and clear go from accept straight to the result state. Lookup and remove read every held
// entry through the store's single read port, one per cycle, before the result state. In the
// cycle the result turns valid the sequencer is idle again and the next item can be taken.
// One item is in work at a time; a new item is taken while the last result waits.
// rst_n (synchronous) empties the store at once; store contents are left as they are.
// A result not yet taken holds the next item in the result state until out_tready.
`include "bounded_value_list_macros.svh"

module bounded_value_list #(
  parameter int DEPTH = bvl_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [0] found, [6:1] removed_count, [12:7] entry_count,
                                  // [13] status, [15:14] zero
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                             wr_en;
  logic [AW-1:0]                    wr_addr;
  logic signed [bvl_pkg::VAL_W-1:0] wr_data;
  logic                             rd_en;
  logic [AW-1:0]                    rd_addr;
  logic signed [bvl_pkg::VAL_W-1:0] rd_data;
  bvl_pkg::result_t                 res;

  bvl_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_type  (bvl_pkg::req_t'(in_tuser)),
    .req_value (in_tdata),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  bvl_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_tdata = {2'b00, res};

  // an accepted item keeps the sequencer busy for at least the next cycle
  `BVL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // a refused append reports no match and no removal
  `BVL_ASSERT_IMPLY(a_refused_clean, clk, rst_n, out_tvalid && out_tdata[13], out_tdata[6:0] == 7'd0)
  // the store is never read and written in the same cycle at the same entry
  `BVL_ASSERT_IMPLY(a_no_rw_clash, clk, rst_n, wr_en && rd_en, wr_addr != rd_addr)
  // write addresses stay inside the store
  `BVL_ASSERT_IMPLY(a_wr_in_range, clk, rst_n, wr_en, (32'(wr_addr)) < DEPTH)

endmodule

// ===== verif/bounded_value_list_tb.sv =====
// Self-checking testbench for bounded_value_list: directed and random requests against a store model.
module bounded_value_list_tb;

  localparam int DEPTH      = bvl_pkg::DEPTH_DEF;
  localparam int FW         = bvl_pkg::FLD_W;
  localparam int RAND_ITEMS = 2000;
  localparam int QUIET_TAIL = 300;   // final random items with no idling on either side

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;    // [31:0] value
  logic [1:0]  in_tuser;    // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;   // [0] found, [6:1] removed_count, [12:7] entry_count, [13] status

  logic [31:0]      held[$];       // predicted store contents, head first
  bvl_pkg::result_t pending[$];    // expected results, oldest first
  logic [31:0]      pool[8];       // small value set so lookups and removes hit often
  bit               in_idle_on;
  bit               out_idle_on;
  int               stall_req;     // long receiver hold-off, in cycles
  int               mismatches;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bounded_value_list dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Updates the predicted store and returns the result the request should produce.
  function automatic bvl_pkg::result_t apply_req(bvl_pkg::req_t kind, logic [31:0] val);
    bvl_pkg::result_t r;
    logic [31:0]      kept[$];
    int               n;
    r = '0;
    n = 0;
    case (kind)
      bvl_pkg::REQ_APPEND: begin
        if (held.size() >= DEPTH) r.status = 1'b1;
        else held.push_back(val);
      end
      bvl_pkg::REQ_LOOKUP: begin
        foreach (held[i]) if (held[i] == val) r.found = 1'b1;
      end
      bvl_pkg::REQ_REMOVE: begin
        foreach (held[i]) begin
          if (held[i] == val) n++;
          else kept.push_back(held[i]);
        end
        held = kept;
        r.found = (n != 0);
        r.removed_count = FW'(n);
      end
      default: begin
        held.delete();
      end
    endcase
    r.entry_count = FW'(held.size());
    return r;
  endfunction

  // Call right after a rising edge; returns at the edge where the item is taken.
  task automatic send_req(input bvl_pkg::req_t kind, input logic [31:0] val);
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= val;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending.push_back(apply_req(kind, val));
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return pool[$urandom_range(0, 7)];
    if (r < 8 && held.size() != 0) return held[$urandom_range(0, held.size() - 1)];
    if (r == 9) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  function automatic bvl_pkg::req_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return bvl_pkg::REQ_APPEND;
    if (r < 72) return bvl_pkg::REQ_LOOKUP;
    if (r < 97) return bvl_pkg::REQ_REMOVE;
    return bvl_pkg::REQ_CLEAR;
  endfunction

  task automatic test_empty_and_extremes();
    send_req(bvl_pkg::REQ_CLEAR,  32'h0000_0000);
    send_req(bvl_pkg::REQ_LOOKUP, 32'h0000_0000);
    send_req(bvl_pkg::REQ_REMOVE, 32'hffff_ffff);
    send_req(bvl_pkg::REQ_APPEND, 32'h8000_0000);
    send_req(bvl_pkg::REQ_APPEND, 32'h7fff_ffff);
    send_req(bvl_pkg::REQ_APPEND, 32'h0000_0000);
    send_req(bvl_pkg::REQ_APPEND, 32'hffff_ffff);
    send_req(bvl_pkg::REQ_LOOKUP, 32'h8000_0000);
    send_req(bvl_pkg::REQ_LOOKUP, 32'h7fff_fffe);   // near miss on the low bit
    send_req(bvl_pkg::REQ_LOOKUP, 32'hffff_ffff);
    send_req(bvl_pkg::REQ_REMOVE, 32'h7fff_ffff);
    send_req(bvl_pkg::REQ_LOOKUP, 32'h7fff_ffff);
    send_req(bvl_pkg::REQ_REMOVE, 32'h0000_0000);
    send_req(bvl_pkg::REQ_CLEAR,  32'hffff_ffff);
    send_req(bvl_pkg::REQ_LOOKUP, 32'h8000_0000);
    settle();
  endtask

  task automatic test_remove_all_matches();
    send_req(bvl_pkg::REQ_APPEND, 32'd5);
    send_req(bvl_pkg::REQ_APPEND, 32'd7);
    send_req(bvl_pkg::REQ_APPEND, 32'd5);
    send_req(bvl_pkg::REQ_APPEND, 32'd5);
    send_req(bvl_pkg::REQ_APPEND, 32'd9);
    send_req(bvl_pkg::REQ_APPEND, 32'd5);
    send_req(bvl_pkg::REQ_REMOVE, 32'd5);
    send_req(bvl_pkg::REQ_REMOVE, 32'd5);
    send_req(bvl_pkg::REQ_LOOKUP, 32'd7);
    send_req(bvl_pkg::REQ_REMOVE, 32'd7);
    send_req(bvl_pkg::REQ_REMOVE, 32'd9);
    settle();
  endtask

  task automatic test_full_store();
    for (int i = 0; i < DEPTH; i++) send_req(bvl_pkg::REQ_APPEND, 32'h0101_0101 * i);
    send_req(bvl_pkg::REQ_APPEND, 32'hdead_beef);   // refused
    send_req(bvl_pkg::REQ_APPEND, 32'h0000_0000);   // refused, though already held
    send_req(bvl_pkg::REQ_LOOKUP, 32'h0000_0000);
    send_req(bvl_pkg::REQ_LOOKUP, 32'h0101_0101 * (DEPTH - 1));
    send_req(bvl_pkg::REQ_REMOVE, 32'h0101_0101 * (DEPTH - 1));
    send_req(bvl_pkg::REQ_APPEND, 32'h1234_5678);
    send_req(bvl_pkg::REQ_APPEND, 32'h1234_5679);   // full again
    send_req(bvl_pkg::REQ_CLEAR,  32'h0000_0000);
    settle();
  endtask

  // Receiver stops for a long stretch while items keep coming, so the input stalls.
  task automatic test_input_stall();
    in_idle_on = 1'b0;
    stall_req = 300;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 2) send_req(bvl_pkg::REQ_LOOKUP, pool[i % 8]);
      else send_req(bvl_pkg::REQ_APPEND, pool[i % 8]);
    end
    settle();
    in_idle_on = 1'b1;
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 64 == 0) begin
        foreach (pool[k]) pool[k] = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 15);
      end
      if (i == RAND_ITEMS / 2) stall_req = 150;
      if (i == RAND_ITEMS - QUIET_TAIL) begin
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
      end
      send_req(pick_kind(), pick_value());
    end
    settle();
  endtask

  // Result side: random ready bursts plus the requested long hold-off.
  initial begin
    int hold;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req > 0) begin
        hold = stall_req;
        stall_req = 0;
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    bvl_pkg::result_t want;
    bvl_pkg::result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[13:0];
      if (pending.size() == 0) begin
        $error("result with nothing expected: out_tdata=%h", out_tdata);
        mismatches++;
      end else begin
        want = pending.pop_front();
        if (got.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, got.found);
          mismatches++;
        end
        if (got.removed_count !== want.removed_count) begin
          $error("removed_count: expected %0d, got %0d", want.removed_count, got.removed_count);
          mismatches++;
        end
        if (got.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= bvl_pkg::REQ_APPEND;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    stall_req   = 0;
    mismatches  = 0;
    foreach (pool[k]) pool[k] = $urandom;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_and_extremes();
    test_remove_all_matches();
    test_full_store();
    test_input_stall();
    test_random_mix();
    // a full walk of the store plus margin, in case a stray result follows
    repeat (4 * DEPTH) @(posedge clk);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
